// ===== rtl/mrq_pkg.sv =====
// Package for the message ring queue: sizes, command and status codes,
// the slot and result types, and the pointer arithmetic helpers.
// No dependencies.
`default_nettype none

package mrq_pkg;

  localparam int DEPTH   = 32;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int POS_W   = 5;
  localparam int COUNT_W = 5;
  localparam int CMP_W   = (PTR_W > POS_W) ? PTR_W : POS_W;

  localparam logic [PTR_W:0] DepthExt = (PTR_W + 1)'(DEPTH);
  localparam logic [PTR_W-1:0] LastSlot = PTR_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_MOVE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_MOVE = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] message_id;
    logic [7:0]  sender;
    logic [63:0] payload;
    logic [31:0] sequence_no;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    status_e              status;
    logic                 dropped_oldest;
    slot_t                msg;
    logic [COUNT_W-1:0]   count;
  } result_t;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == LastSlot) ? '0 : p + 1'b1;
  endfunction

  // Number of messages held between the read and write pointers.
  function automatic logic [PTR_W-1:0] held(input logic [PTR_W-1:0] wp,
                                            input logic [PTR_W-1:0] rp);
    logic [PTR_W:0] t;
    t = {1'b0, wp} + DepthExt - {1'b0, rp};
    if (wp >= rp) begin
      return wp - rp;
    end
    return t[PTR_W-1:0];
  endfunction

  // Slot index of a position counted from the oldest message. The position
  // is always below the fill level, so one wrap correction is enough.
  function automatic logic [PTR_W-1:0] slot_at(input logic [PTR_W-1:0] rp,
                                               input logic [PTR_W-1:0] pos);
    logic [PTR_W:0] s;
    s = {1'b0, rp} + {1'b0, pos};
    if (s >= DepthExt) begin
      s = s - DepthExt;
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic pos_below(input logic [POS_W-1:0] pos,
                                     input logic [PTR_W-1:0] n);
    return CMP_W'(pos) < CMP_W'(n);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mrq_in_if.sv =====
// Command channel of the message ring queue: valid/ready and one command.
// No dependencies.
`default_nettype none

interface mrq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] message_id;
  logic [7:0]  sender;
  logic [63:0] payload;
  logic [4:0]  position_a;
  logic [4:0]  position_b;

  modport source (output valid, command, message_id, sender, payload, position_a,
                  position_b, input ready);
  modport sink (input valid, command, message_id, sender, payload, position_a,
                position_b, output ready);
endinterface

`default_nettype wire

// ===== rtl/mrq_out_if.sv =====
// Result channel of the message ring queue: valid/ready and one result.
// No dependencies.
`default_nettype none

interface mrq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        dropped_oldest;
  logic [15:0] out_message_id;
  logic [7:0]  out_sender;
  logic [63:0] out_payload;
  logic [31:0] out_sequence;
  logic [4:0]  count;

  modport source (output valid, status, dropped_oldest, out_message_id, out_sender,
                  out_payload, out_sequence, count, input ready);
  modport sink (input valid, status, dropped_oldest, out_message_id, out_sender,
                out_payload, out_sequence, count, output ready);
endinterface

`default_nettype wire

// ===== rtl/message_ring_queue.sv =====
// Message ring queue, top level: overflow mode register, command sequencer
// and the result output register. Depends on mrq_pkg, mrq_in_if, mrq_out_if
// and mrq_ctrl.
// Push goes from the idle state straight to the result state; pop and peek
// pass through the read state; a move walks the slots from position_b down
// to position_a. One command is in flight at a time; a new command is taken
// once the previous result has been transferred into the output register.
// Reset: asynchronous, active low; queue empty, sequence counter zero,
// overflow mode zero (reject when full). Slot contents are not cleared.
`default_nettype none

module message_ring_queue (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i,
  mrq_in_if.sink    in_ch,
  mrq_out_if.source out_ch
);
  import mrq_pkg::*;

  logic    mode_q;
  logic    res_valid, res_ready;
  result_t res;
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  mrq_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .overflow_mode_i (mode_q),
    .in_ch           (in_ch),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  // The output register takes a new result whenever it is empty or its
  // current result is being transferred out in the same cycle.
  assign res_ready = !out_valid_q || out_ch.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.status         = out_q.status;
  assign out_ch.dropped_oldest = out_q.dropped_oldest;
  assign out_ch.out_message_id = out_q.msg.message_id;
  assign out_ch.out_sender     = out_q.msg.sender;
  assign out_ch.out_payload    = out_q.msg.payload;
  assign out_ch.out_sequence   = out_q.msg.sequence_no;
  assign out_ch.count          = out_q.count;

endmodule

`default_nettype wire

// ===== rtl/mrq_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module mrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/mrq_ctrl.sv =====
// Command sequencer of the message ring queue: pointers, sequence counter,
// and the read-modify-write walk over the slot RAM.
// Depends on mrq_pkg, mrq_in_if and mrq_ram.
`default_nettype none

module mrq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           overflow_mode_i,
  mrq_in_if.sink              in_ch,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output mrq_pkg::result_t    res_o
);
  import mrq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_READ     = 6'b000010,
    S_MV_SRC   = 6'b000100,
    S_MV_SHIFT = 6'b001000,
    S_MV_LAST  = 6'b010000,
    S_RESP     = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [31:0]       seq_q, seq_d;
  logic [PTR_W-1:0]  pa_q, pa_d, pos_q, pos_d;
  slot_t             tmp_q, tmp_d;
  result_t           res_q, res_d;

  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr, mem_raddr;
  slot_t             mem_wdata, mem_rdata;

  logic              accept;
  logic [PTR_W-1:0]  fill;
  logic              full;
  slot_t             push_slot;

  assign in_ch.ready = (state_q == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign fill        = held(wp_q, rp_q);
  assign full        = (fill >= LastSlot);

  assign push_slot.message_id  = in_ch.message_id;
  assign push_slot.sender      = in_ch.sender;
  assign push_slot.payload     = in_ch.payload;
  assign push_slot.sequence_no = seq_q + 32'd1;

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    seq_d     = seq_q;
    pa_d      = pa_q;
    pos_d     = pos_q;
    tmp_d     = tmp_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = wp_q;
    mem_wdata = push_slot;
    mem_raddr = rp_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d   = '0;
          state_d = S_RESP;
          case (cmd_e'(in_ch.command))
            CMD_PUSH: begin
              if (full && !overflow_mode_i) begin
                res_d.status = ST_FULL;
              end else begin
                if (full) begin
                  rp_d                 = wrap_inc(rp_q);
                  res_d.dropped_oldest = 1'b1;
                end
                mem_we                  = 1'b1;
                wp_d                    = wrap_inc(wp_q);
                seq_d                   = seq_q + 32'd1;
                res_d.msg.sequence_no   = seq_q + 32'd1;
              end
            end
            CMD_POP: begin
              if (fill == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                mem_raddr = rp_q;
                rp_d      = wrap_inc(rp_q);
                state_d   = S_READ;
              end
            end
            CMD_PEEK: begin
              if (!pos_below(in_ch.position_a, fill)) begin
                res_d.status = ST_EMPTY;
              end else begin
                mem_raddr = slot_at(rp_q, PTR_W'(in_ch.position_a));
                state_d   = S_READ;
              end
            end
            CMD_MOVE: begin
              if (!pos_below(in_ch.position_a, fill) ||
                  !pos_below(in_ch.position_b, fill)) begin
                res_d.status = ST_EMPTY;
              end else if (in_ch.position_b <= in_ch.position_a) begin
                res_d.status = ST_BAD_MOVE;
              end else begin
                mem_raddr = slot_at(rp_q, PTR_W'(in_ch.position_b));
                pa_d      = PTR_W'(in_ch.position_a);
                pos_d     = PTR_W'(in_ch.position_b);
                state_d   = S_MV_SRC;
              end
            end
            default: begin
              res_d.status = ST_EMPTY;
            end
          endcase
        end
      end

      S_READ: begin
        res_d.msg = mem_rdata;
        state_d   = S_RESP;
      end

      // The moved message is held aside while the messages in between
      // shift back one slot, one RAM read and one write per cycle.
      S_MV_SRC: begin
        tmp_d     = mem_rdata;
        mem_raddr = slot_at(rp_q, pos_q - 1'b1);
        state_d   = S_MV_SHIFT;
      end

      S_MV_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = slot_at(rp_q, pos_q);
        mem_wdata = mem_rdata;
        pos_d     = pos_q - 1'b1;
        if ((pos_q - 1'b1) == pa_q) begin
          state_d = S_MV_LAST;
        end else begin
          mem_raddr = slot_at(rp_q, pos_q - PTR_W'(2));
        end
      end

      S_MV_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = slot_at(rp_q, pa_q);
        mem_wdata = tmp_q;
        state_d   = S_RESP;
      end

      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.count = COUNT_W'(held(wp_d, rp_d));
  end

  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wp_q    <= '0;
      rp_q    <= '0;
      seq_q   <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      seq_q   <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q  <= pa_d;
    pos_q <= pos_d;
    tmp_q <= tmp_d;
    res_q <= res_d;
  end

  mrq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The sequence counter only advances on a push taken in the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> $stable(seq_q))
    else $error("sequence counter changed outside a push");

  // A move walk leaves both pointers alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MV_SHIFT || state_q == S_MV_SRC) |=> $stable(rp_q) && $stable(wp_q))
    else $error("pointer changed during a move");

  // The walk never passes the destination position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MV_SHIFT) |-> (pos_q > pa_q))
    else $error("move walk passed its destination");

  // In the idle state the RAM is written only by an accepted push.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == S_IDLE) |-> (accept && in_ch.command == CMD_PUSH))
    else $error("slot write without a push");

endmodule

`default_nettype wire
